FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Delayed implication from antecedent to consequent.
`define ASSERT_DELAY2(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

FILE: rtl/efr_pkg.sv
// Shared types, register indexes and the CRC-8 step for the frame receiver.
package efr_pkg;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_CHECK   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_DATA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_ACK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_NAK   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE      = 3'd6;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  localparam logic [7:0] CRC_POLY   = 8'h85;
  localparam int         RESULT_CAP = 62;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // input byte transfer this cycle
    logic clr_idx;  // restart the drain index
    logic rd_en;    // read payload store at the drain index
    logic inc_idx;  // step the drain index
  } efr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic deliver;  // accepted byte closes a frame that is to be emitted
    logic last;     // drain index sits on the final payload byte
  } efr_sts_t;

  // one byte through the CRC-8, MSB first
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/efr_dp.sv
// Datapath: config registers, frame parser, CRC, payload store and result registers.
module efr_dp #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [efr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata,
  input  logic [7:0]                    in_rx_byte,
  input  efr_pkg::efr_cmd_t             cmd,
  output efr_pkg::efr_sts_t             sts,
  output logic [1:0]                    out_frame_kind,
  output logic [15:0]                   out_command,
  output logic [7:0]                    out_payload_byte,
  output logic [5:0]                    out_payload_index,
  output logic [5:0]                    out_payload_length,
  output logic                          out_crc_ok,
  output logic                          out_is_last
);

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int CW  = $clog2(BUFFER_DEPTH + 1);
  localparam int KW  = (CW > 7) ? CW : 7;
  localparam int CAP = (BUFFER_DEPTH - 2 < efr_pkg::RESULT_CAP) ?
                       BUFFER_DEPTH - 2 : efr_pkg::RESULT_CAP;

  // configuration
  logic [5:0] max_payload_r;
  logic       crc_check_r;
  logic [7:0] start_data_r, start_ack_r, start_nak_r, end_r, esc_r;

  // frame state
  logic          in_frame_r, in_frame_nxt;
  logic [1:0]    hdr_left_r, hdr_left_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [15:0]   command_r, command_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [7:0]    last_byte_r, last_byte_nxt;   // most recent stored byte, not yet in the CRC
  logic [5:0]    len_r, len_nxt;
  logic          ok_r, ok_nxt;

  // drain side
  logic [5:0] idx_r;
  logic [7:0] rd_data_r;
  logic [7:0] mem [BUFFER_DEPTH];

  logic [5:0] lim;
  logic [7:0] fold_in, fold_out, calc;
  logic       crc_match, we, do_store, chk_len, deliver;

  assign lim      = (max_payload_r > 6'(CAP)) ? 6'(CAP) : max_payload_r;
  assign fold_in  = (hdr_left_r != 2'd0) ? in_rx_byte : last_byte_r;
  assign fold_out = efr_pkg::crc8_fold(crc_r, fold_in);
  // a computed CRC that collides with the end or escape byte is sent as zero
  assign calc      = (crc_r == end_r || crc_r == esc_r) ? 8'd0 : crc_r;
  assign crc_match = (calc == last_byte_r);

  always_comb begin
    in_frame_nxt  = in_frame_r;
    hdr_left_nxt  = hdr_left_r;
    prev_nxt      = prev_r;
    kind_nxt      = kind_r;
    command_nxt   = command_r;
    count_nxt     = count_r;
    crc_nxt       = crc_r;
    last_byte_nxt = last_byte_r;
    len_nxt       = len_r;
    ok_nxt        = ok_r;
    we            = 1'b0;
    do_store      = 1'b0;
    chk_len       = 1'b0;
    deliver       = 1'b0;
    if (cmd.accept) begin
      if (!in_frame_r) begin
        if (in_rx_byte == start_data_r || in_rx_byte == start_ack_r ||
            in_rx_byte == start_nak_r) begin
          in_frame_nxt = 1'b1;
          hdr_left_nxt = 2'd2;
          prev_nxt     = ~esc_r;
          command_nxt  = '0;
          count_nxt    = '0;
          crc_nxt      = '0;
          if (in_rx_byte == start_data_r) begin
            kind_nxt = efr_pkg::KIND_DATA;
          end else if (in_rx_byte == start_ack_r) begin
            kind_nxt = efr_pkg::KIND_ACK;
          end else begin
            kind_nxt = efr_pkg::KIND_NAK;
          end
        end
      end else if (hdr_left_r != 2'd0) begin
        command_nxt  = {command_r[7:0], in_rx_byte};
        crc_nxt      = fold_out;
        hdr_left_nxt = hdr_left_r - 2'd1;
      end else begin
        if (prev_r == esc_r) begin
          do_store = 1'b1;
          chk_len  = 1'b1;
          prev_nxt = (in_rx_byte == esc_r) ? ~esc_r : in_rx_byte;
        end else if (in_rx_byte == esc_r) begin
          chk_len  = 1'b1;
          prev_nxt = in_rx_byte;
        end else if (in_rx_byte == end_r) begin
          prev_nxt     = in_rx_byte;
          in_frame_nxt = 1'b0;
          hdr_left_nxt = 2'd0;
          count_nxt    = '0;
          if (count_r > CW'(1)) begin
            len_nxt = 6'(count_r - CW'(1));
            ok_nxt  = crc_match;
            deliver = crc_match || !crc_check_r;
          end
        end else begin
          do_store = 1'b1;
          chk_len  = 1'b1;
          prev_nxt = in_rx_byte;
        end
        if (do_store) begin
          if (count_r != '0) begin
            crc_nxt = fold_out;
          end
          last_byte_nxt = in_rx_byte;
          count_nxt     = count_r + CW'(1);
          we            = (count_r < CW'(BUFFER_DEPTH));
        end
        // overlong frame
        if (chk_len && (KW'(count_nxt) > KW'(lim) + KW'(1))) begin
          in_frame_nxt = 1'b0;
          hdr_left_nxt = 2'd0;
          count_nxt    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= 6'd62;
      crc_check_r   <= 1'b1;
      start_data_r  <= 8'd2;
      start_ack_r   <= 8'd6;
      start_nak_r   <= 8'd21;
      end_r         <= 8'd3;
      esc_r         <= 8'd27;
    end else if (cfg_we) begin
      case (cfg_index)
        efr_pkg::REG_MAX_PAYLOAD: max_payload_r <= cfg_wdata[5:0];
        efr_pkg::REG_CRC_CHECK:   crc_check_r   <= cfg_wdata[0];
        efr_pkg::REG_START_DATA:  start_data_r  <= cfg_wdata;
        efr_pkg::REG_START_ACK:   start_ack_r   <= cfg_wdata;
        efr_pkg::REG_START_NAK:   start_nak_r   <= cfg_wdata;
        efr_pkg::REG_END:         end_r         <= cfg_wdata;
        efr_pkg::REG_ESCAPE:      esc_r         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      hdr_left_r <= 2'd0;
      prev_r     <= 8'd0;
      kind_r     <= 2'd0;
      command_r  <= 16'd0;
      count_r    <= '0;
      crc_r      <= 8'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      hdr_left_r <= hdr_left_nxt;
      prev_r     <= prev_nxt;
      kind_r     <= kind_nxt;
      command_r  <= command_nxt;
      count_r    <= count_nxt;
      crc_r      <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_byte_r <= last_byte_nxt;
    len_r       <= len_nxt;
    ok_r        <= ok_nxt;
    if (cmd.clr_idx) begin
      idx_r <= 6'd0;
    end else if (cmd.inc_idx) begin
      idx_r <= idx_r + 6'd1;
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[count_r[AW-1:0]] <= in_rx_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[AW'(idx_r)];
    end
  end

  assign sts.deliver = deliver;
  assign sts.last    = (idx_r + 6'd1 == len_r);

  assign out_frame_kind     = kind_r;
  assign out_command        = command_r;
  assign out_payload_byte   = rd_data_r;
  assign out_payload_index  = idx_r;
  assign out_payload_length = len_r;
  assign out_crc_ok         = ok_r;
  assign out_is_last        = sts.last;

endmodule

FILE: rtl/efr_ctrl.sv
// Controller: takes bytes while idle and sequences the payload drain.
module efr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  efr_pkg::efr_sts_t sts,
  output efr_pkg::efr_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHOW
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid && !in_stall_r;
        if (cmd.accept && sts.deliver) begin
          cmd.clr_idx = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SHOW;
      end
      S_SHOW: begin
        if (!out_stall) begin
          if (sts.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.inc_idx = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_stall_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= (state_nxt != S_IDLE);
      out_valid_r <= (state_nxt == S_SHOW);
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/escaped_frame_receiver_crc8.sv
// Byte-stuffed frame receiver with CRC-8 check: one byte accepted per cycle while idle.
// After the end byte transfer the controller reads the store (S_READ) and then offers
// the first payload result (S_SHOW); it transfers once out_stall is low.
// Each payload result needs a store read, then the output register (S_SHOW),
// plus any output stall; no input byte is taken while a frame drains.
// Reset: synchronous active-low rst_n clears frame state and loads register defaults.
module escaped_frame_receiver_crc8 #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [efr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_frame_kind,
  output logic [15:0]                   out_command,
  output logic [7:0]                    out_payload_byte,
  output logic [5:0]                    out_payload_index,
  output logic [5:0]                    out_payload_length,
  output logic                          out_crc_ok,
  output logic                          out_is_last
);

  efr_pkg::efr_cmd_t cmd;
  efr_pkg::efr_sts_t sts;

  efr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  efr_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_rx_byte         (in_rx_byte),
    .cmd                (cmd),
    .sts                (sts),
    .out_frame_kind     (out_frame_kind),
    .out_command        (out_command),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_payload_length (out_payload_length),
    .out_crc_ok         (out_crc_ok),
    .out_is_last        (out_is_last)
  );

endmodule

FILE: rtl/efr_chk.sv
// Port-level checker for the frame receiver, bound to the top level.
`include "assert_macros.svh"

module efr_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_payload_byte,
  input logic [5:0] out_payload_index,
  input logic [5:0] out_payload_length,
  input logic       out_is_last
);

  // no byte transfer while a result is on offer
  `ASSERT_IMPLIES(a_busy_while_out, clk, rst_n, out_valid, in_stall, "input open during drain")

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload_byte), "stalled result changed")

  `ASSERT_NEXT(a_drain_busy, clk, rst_n, out_valid && !out_stall && !out_is_last, in_stall, "input reopened mid-run")

  `ASSERT_DELAY2(a_index_step, clk, rst_n, out_valid && !out_stall && !out_is_last, out_valid && out_payload_index == 6'($past(out_payload_index, 2) + 6'd1), "payload index did not step")

  `ASSERT_IMPLIES(a_index_range, clk, rst_n, out_valid, out_payload_index < out_payload_length, "index beyond length")

endmodule

bind escaped_frame_receiver_crc8 efr_chk u_efr_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_payload_byte   (out_payload_byte),
  .out_payload_index  (out_payload_index),
  .out_payload_length (out_payload_length),
  .out_is_last        (out_is_last)
);

FILE: sim/tb_top.sv
// Self-checking testbench for the byte-stuffed CRC-8 frame receiver.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] POLY8 = 8'h85;
  localparam int QUIET_LIMIT = 3000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] cmd;
    logic [7:0]  data;
    logic [5:0]  idx;
    logic [5:0]  len;
    logic        ok;
    logic        last;
  } payload_beat_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [efr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                    cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    in_rx_byte = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [1:0]                    out_frame_kind;
  logic [15:0]                   out_command;
  logic [7:0]                    out_payload_byte;
  logic [5:0]                    out_payload_index;
  logic [5:0]                    out_payload_length;
  logic                          out_crc_ok;
  logic                          out_is_last;

  escaped_frame_receiver_crc8 DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_kind     (out_frame_kind),
    .out_command        (out_command),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_payload_length (out_payload_length),
    .out_crc_ok         (out_crc_ok),
    .out_is_last        (out_is_last)
  );

  // register copies, reset values
  logic [5:0] lim_reg = 6'd62;
  logic       chk_reg = 1'b1;
  logic [7:0] sdata = 8'h02, sack = 8'h06, snak = 8'h15, endb = 8'h03, escb = 8'h1B;

  // receiver state
  logic        fr_open = 1'b0;
  int          hdr_left = 0;
  logic [7:0]  prev_b = 8'h00;
  logic [1:0]  kind_q = efr_pkg::KIND_DATA;
  logic [15:0] cmd_q = '0;
  int          n_stored = 0;
  logic [7:0]  store [64];
  logic [7:0]  crc_run = 8'h00;

  payload_beat_t beats_due[$];
  logic [7:0]    rx_pending[$];
  logic [7:0]    frame_body[$];
  int            bytes_queued = 0;
  int            err_count = 0;
  int            quiet_cycles = 0;
  int            send_gap_pct = 9;
  int            recv_stall_pct = 49;

  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] v);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ v[i];
      c = {c[6:0], 1'b0} ^ (fb ? POLY8 : 8'h00);
    end
    return c;
  endfunction

  // previous stored byte joins the CRC only once a later one proves it is not the CRC
  function void stash(input logic [7:0] r);
    if (n_stored >= 1 && n_stored <= 64) crc_run = crc8_step(crc_run, store[n_stored-1]);
    if (n_stored < 64) store[n_stored] = r;
    n_stored = (n_stored + 1) & 127;
  endfunction

  function void decode_byte(input logic [7:0] r);
    logic [7:0]    no_esc;
    logic [7:0]    rx_crc;
    logic [7:0]    calc;
    int            lim;
    int            len;
    payload_beat_t b;
    no_esc = ~escb;
    lim = (lim_reg > 62) ? 62 : lim_reg;
    if (!fr_open) begin
      if (r == sdata) kind_q = efr_pkg::KIND_DATA;
      else if (r == sack) kind_q = efr_pkg::KIND_ACK;
      else if (r == snak) kind_q = efr_pkg::KIND_NAK;
      else return;
      fr_open = 1'b1;
      hdr_left = 2;
      prev_b = no_esc;
      cmd_q = '0;
      n_stored = 0;
      crc_run = 8'h00;
      return;
    end
    if (hdr_left != 0) begin
      cmd_q = {cmd_q[7:0], r};
      crc_run = crc8_step(crc_run, r);
      hdr_left--;
      return;
    end
    if (prev_b == escb) begin
      stash(r);
      prev_b = (r == escb) ? no_esc : r;
    end else if (r == endb && r != escb) begin
      prev_b = r;
      fr_open = 1'b0;
      hdr_left = 0;
      if (n_stored <= 1) begin
        n_stored = 0;
        return;
      end
      len = n_stored - 1;
      rx_crc = store[len];
      calc = (crc_run == endb || crc_run == escb) ? 8'h00 : crc_run;
      n_stored = 0;
      if (calc != rx_crc && chk_reg) return;
      for (int k = 0; k < len; k++) begin
        b.kind = kind_q;
        b.cmd  = cmd_q;
        b.data = store[k];
        b.idx  = 6'(k);
        b.len  = 6'(len);
        b.ok   = (calc == rx_crc);
        b.last = (k == len - 1);
        beats_due.push_back(b);
      end
      return;
    end else begin
      if (r != escb) stash(r);
      prev_b = r;
    end
    if (n_stored > lim + 1) begin
      fr_open = 1'b0;
      hdr_left = 0;
      n_stored = 0;
    end
  endfunction

  function void send_raw(input logic [7:0] b);
    rx_pending.push_back(b);
    bytes_queued++;
  endfunction

  // escape where needed, and now and then where not
  function void send_lit(input logic [7:0] b);
    if (b == escb || b == endb || $urandom_range(0, 15) == 0) send_raw(escb);
    send_raw(b);
  endfunction

  function void fill_body(input int n);
    frame_body.delete();
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: frame_body.push_back(escb);
        1: frame_body.push_back(endb);
        2: frame_body.push_back(sdata);
        default: frame_body.push_back(8'($urandom));
      endcase
    end
  endfunction

  function void queue_frame(input logic [7:0] opener, input logic [15:0] cmd,
                            input bit with_crc, input bit bad_crc);
    logic [7:0] c;
    c = crc8_step(crc8_step(8'h00, cmd[15:8]), cmd[7:0]);
    foreach (frame_body[i]) c = crc8_step(c, frame_body[i]);
    if (c == endb || c == escb) c = 8'h00;
    if (bad_crc) c ^= 8'h01 << $urandom_range(0, 7);
    send_raw(opener);
    send_raw(cmd[15:8]);
    send_raw(cmd[7:0]);
    foreach (frame_body[i]) send_lit(frame_body[i]);
    if (with_crc) send_lit(c);
    send_raw(endb);
    frame_body.delete();
  endfunction

  function void queue_random_frame();
    int          sel;
    int          n;
    int          lim;
    logic [7:0]  opener;
    logic [7:0]  nb;
    logic [15:0] cmd;
    sel = $urandom_range(0, 99);
    lim = (lim_reg > 62) ? 62 : lim_reg;
    cmd = 16'($urandom);
    case ($urandom_range(0, 2))
      0: opener = sdata;
      1: opener = sack;
      default: opener = snak;
    endcase
    n = $urandom_range(1, (lim < 6) ? lim : 6);
    if (lim <= 8 && sel < 10) n = lim + 1;
    else if (lim <= 8 && sel < 20) n = lim;
    if (sel >= 20 && sel < 30) begin
      fill_body(n);
      queue_frame(opener, cmd, 1'b1, 1'b1);
    end else if (sel >= 30 && sel < 36) begin
      // nothing but header, or header and CRC
      queue_frame(opener, cmd, sel[0], 1'b0);
    end else begin
      if (sel >= 36 && sel < 46) begin
        repeat ($urandom_range(1, 3)) begin
          do nb = 8'($urandom); while (nb == sdata || nb == sack || nb == snak);
          send_raw(nb);
        end
      end
      fill_body(n);
      queue_frame(opener, cmd, 1'b1, 1'b0);
    end
  endfunction

  function void queue_random_run(input int target);
    int stop_at;
    stop_at = bytes_queued + target;
    while (bytes_queued < stop_at) queue_random_frame();
  endfunction

  function void check_field(input string fname, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      err_count++;
    end
  endfunction

  task automatic write_reg(input logic [efr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      efr_pkg::REG_MAX_PAYLOAD: lim_reg = val[5:0];
      efr_pkg::REG_CRC_CHECK:   chk_reg = val[0];
      efr_pkg::REG_START_DATA:  sdata = val;
      efr_pkg::REG_START_ACK:   sack = val;
      efr_pkg::REG_START_NAK:   snak = val;
      efr_pkg::REG_END:         endb = val;
      efr_pkg::REG_ESCAPE:      escb = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [7:0] mp, chk, sd, sa, sn, e, x);
    write_reg(efr_pkg::REG_MAX_PAYLOAD, mp);
    write_reg(efr_pkg::REG_CRC_CHECK, chk);
    write_reg(efr_pkg::REG_START_DATA, sd);
    write_reg(efr_pkg::REG_START_ACK, sa);
    write_reg(efr_pkg::REG_START_NAK, sn);
    write_reg(efr_pkg::REG_END, e);
    write_reg(efr_pkg::REG_ESCAPE, x);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold the sender until every queued byte is taken and every payload transfer is back
  task automatic settle();
    do @(posedge clk); while (rx_pending.size() != 0 || in_valid || beats_due.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_rx_byte);
        void'(rx_pending.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_pending[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // payload monitor
  always @(posedge clk) begin : payload_mon
    payload_beat_t want;
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (beats_due.size() == 0) begin
        $error("payload transfer 0x%0h with nothing outstanding", out_payload_byte);
        err_count++;
      end else begin
        want = beats_due.pop_front();
        check_field("frame_kind", want.kind, out_frame_kind);
        check_field("command", want.cmd, out_command);
        check_field("payload_byte", want.data, out_payload_byte);
        check_field("payload_index", want.idx, out_payload_index);
        check_field("payload_length", want.len, out_payload_length);
        check_field("crc_ok", want.ok, out_crc_ok);
        check_field("is_last", want.last, out_is_last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] e;
    logic [7:0] x;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: strays, escaped payload, raw header bytes, short and bad frames
    send_raw(8'h00);
    send_raw(8'hFF);
    frame_body = '{8'h1B, 8'h03, 8'hFF};
    queue_frame(sdata, 16'h0302, 1'b1, 1'b0);
    queue_frame(sack, 16'h0000, 1'b0, 1'b0);
    queue_frame(snak, 16'hFFFF, 1'b1, 1'b0);
    frame_body = '{8'h5A};
    queue_frame(sdata, 16'h1234, 1'b1, 1'b1);
    frame_body = '{8'h00};
    queue_frame(sack, 16'hABCD, 1'b1, 1'b0);
    queue_random_run(6);
    settle();

    // short limit: a frame right at the limit, then one byte over
    apply_config(8'd4, 8'd1, 8'h00, 8'hFF, 8'h80, 8'h7E, 8'h7D);
    fill_body(4);
    queue_frame(sdata, 16'($urandom), 1'b1, 1'b0);
    fill_body(5);
    queue_frame(snak, 16'($urandom), 1'b1, 1'b0);
    queue_random_run(4);
    settle();

    send_gap_pct = 49;
    recv_stall_pct = 9;
    // ack shadowed by data; bad CRCs delivered flagged
    apply_config(8'd1, 8'd0, 8'hAA, 8'hAA, 8'h55, 8'hFF, 8'h00);
    queue_random_run(10);
    settle();

    // nak shadowed by ack
    apply_config(8'd5, 8'd1, 8'h10, 8'h20, 8'h20, 8'h03, 8'h1B);
    queue_random_run(10);
    settle();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    x = 8'($urandom);
    do e = 8'($urandom); while (e == x);
    apply_config(8'($urandom_range(1, 62)), 8'($urandom_range(0, 1)), 8'($urandom),
                 8'($urandom), 8'($urandom), e, x);
    queue_random_run(12);
    settle();

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: escaped_frame_receiver_crc8.f
+incdir+rtl
rtl/efr_pkg.sv
rtl/efr_dp.sv
rtl/efr_ctrl.sv
rtl/escaped_frame_receiver_crc8.sv
rtl/efr_chk.sv
sim/tb_top.sv
